// ===== sv/assert_macros.svh =====
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Boris pusher package
// Shared types, register indexes and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package bpp_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int IDX_W         = 3;

    localparam logic [IDX_W-1:0] REG_EFIELD_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_EFIELD_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_EFIELD_Z  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BFIELD_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BFIELD_Y  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BFIELD_Z  = 3'd5;
    localparam logic [IDX_W-1:0] REG_HALF_QMDT = 3'd6;
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd7;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t vec3_t [3];

    typedef struct {
        vec3_t k;
        vec3_t t;
        vec3_t s;
        word_t dt;
    } coef_t;

    function automatic word_t sat64(input logic signed [63:0] x);
        word_t r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic word_t fx_mul(input word_t a, input word_t b, input int frac);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = 64'(a) * 64'(b);
        p = p + (64'sd1 <<< (frac - 1));
        r = p >>> frac;
        return sat64(r);
    endfunction

    function automatic word_t fx_add(input word_t a, input word_t b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat64(s);
    endfunction

    function automatic word_t fx_sub(input word_t a, input word_t b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat64(s);
    endfunction

endpackage

// ===== sv/bpp_sdiv.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpp_sdiv #(
    parameter int NW = 50,
    parameter int DW = 36
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0] rem_sh;
    logic        ge;
    logic [DW:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg[DW-1:0], num_reg[NW-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/bpp_coef.sv =====
// ----------------------------------------------------------------------------
// Coefficient unit
// Holds the configuration and derives the kick, rotation and scale vectors.
// ----------------------------------------------------------------------------
module bpp_coef
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  word_t            cfg_data,
    output coef_t            coef,
    output logic             busy
);

    localparam int NW = WORD_W + FRAC_BITS + 3;
    localparam int DW = WORD_W + 4;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_START = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    word_t         cfg_reg [NUM_REGS];
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    vec3_t         k_reg;
    vec3_t         t_reg;
    vec3_t         s_reg;
    vec3_t         tt_reg;
    logic [DW-1:0] d_reg;
    logic [NW-1:0] dvd_reg [3];
    logic [NW-1:0] quo [3];
    logic [2:0]    done;
    logic [32:0]   mag [3];

    function automatic word_t sat_s(input logic [NW-1:0] q, input logic neg);
        logic [32:0]        qm;
        logic signed [33:0] sv;
        if ((|q[NW-1:32]) || (q[31] && (|q[30:0])))
        begin
            qm = 33'h0_8000_0000;
        end
        else
        begin
            qm = {1'b0, q[31:0]};
        end
        sv = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        return sat64(64'(sv));
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = t_reg[i][WORD_W-1] ? (33'd0 - {t_reg[i][WORD_W-1], t_reg[i]})
                                        : {1'b0, t_reg[i]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = S_IDLE;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_SUM;
            S_SUM:   state_next = S_LOAD;
            S_LOAD:  state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:   state_next = (&done) ? S_FIN : S_DIV;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = S_MUL1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                k_reg[i] <= '0;
                t_reg[i] <= '0;
                s_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            if (state_reg == S_MUL1)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    k_reg[i] <= fx_mul(cfg_reg[REG_HALF_QMDT], cfg_reg[i], FRAC_BITS);
                    t_reg[i] <= fx_mul(cfg_reg[REG_HALF_QMDT], cfg_reg[3 + i], FRAC_BITS);
                end
            end
            if (state_reg == S_FIN)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s_reg[i] <= sat_s(quo[i], t_reg[i][WORD_W-1]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tt_reg[i] <= fx_mul(t_reg[i], t_reg[i], FRAC_BITS);
            end
        end
        if (state_reg == S_SUM)
        begin
            d_reg <= (DW'(1) << FRAC_BITS) + DW'(unsigned'(tt_reg[0]))
                   + DW'(unsigned'(tt_reg[1])) + DW'(unsigned'(tt_reg[2]));
        end
        if (state_reg == S_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dvd_reg[i] <= (NW'(mag[i]) << (FRAC_BITS + 2)) + NW'(d_reg);
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        bpp_sdiv #(
            .NW(NW),
            .DW(DW)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (state_reg == S_START),
            .dividend (dvd_reg[g]),
            .divisor  ({d_reg[DW-2:0], 1'b0}),
            .quotient (quo[g]),
            .done     (done[g])
        );
    end

    assign coef.k  = k_reg;
    assign coef.t  = t_reg;
    assign coef.s  = s_reg;
    assign coef.dt = cfg_reg[REG_TIME_STEP];
    assign busy    = (state_reg != S_IDLE);

endmodule

// ===== sv/bpp_pipe.sv =====
// ----------------------------------------------------------------------------
// Velocity and position pipeline
// Seven register stages: kick, rotation, scale, second kick, position update.
// ----------------------------------------------------------------------------
module bpp_pipe
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  coef_t coef,
    input  logic  in_valid,
    output logic  in_ready,
    input  vec3_t pos,
    input  vec3_t vel,
    output logic  out_valid,
    input  logic  out_stall,
    output vec3_t new_pos,
    output vec3_t new_vel
);

    logic [7:1] v_reg;
    logic [7:1] en;

    vec3_t pos1_reg, pos2_reg, pos3_reg, pos4_reg, pos5_reg, pos6_reg, pos7_reg;
    vec3_t vm1_reg, vm2_reg, vm3_reg, vm4_reg;
    vec3_t pa2_reg, pb2_reg, vq3_reg, pa4_reg, pb4_reg;
    vec3_t nv5_reg, nv6_reg, nv7_reg, m6_reg;

    always_comb
    begin
        en[7] = !v_reg[7] || !out_stall;
        for (int i = 6; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i + 1];
        end
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int i = 2; i <= 7; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos1_reg[i] <= pos[i];
                vm1_reg[i]  <= fx_add(vel[i], coef.k[i]);
            end
        end
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos2_reg[i] <= pos1_reg[i];
                vm2_reg[i]  <= vm1_reg[i];
                pa2_reg[i]  <= fx_mul(vm1_reg[(i + 1) % 3], coef.t[(i + 2) % 3], FRAC_BITS);
                pb2_reg[i]  <= fx_mul(vm1_reg[(i + 2) % 3], coef.t[(i + 1) % 3], FRAC_BITS);
            end
        end
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos3_reg[i] <= pos2_reg[i];
                vm3_reg[i]  <= vm2_reg[i];
                vq3_reg[i]  <= fx_add(vm2_reg[i], fx_sub(pa2_reg[i], pb2_reg[i]));
            end
        end
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos4_reg[i] <= pos3_reg[i];
                vm4_reg[i]  <= vm3_reg[i];
                pa4_reg[i]  <= fx_mul(vq3_reg[(i + 1) % 3], coef.s[(i + 2) % 3], FRAC_BITS);
                pb4_reg[i]  <= fx_mul(vq3_reg[(i + 2) % 3], coef.s[(i + 1) % 3], FRAC_BITS);
            end
        end
        if (en[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos5_reg[i] <= pos4_reg[i];
                nv5_reg[i]  <= fx_add(fx_add(vm4_reg[i], fx_sub(pa4_reg[i], pb4_reg[i])),
                                      coef.k[i]);
            end
        end
        if (en[6])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos6_reg[i] <= pos5_reg[i];
                nv6_reg[i]  <= nv5_reg[i];
                m6_reg[i]   <= fx_mul(coef.dt, nv5_reg[i], FRAC_BITS);
            end
        end
        if (en[7])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos7_reg[i] <= fx_add(pos6_reg[i], m6_reg[i]);
                nv7_reg[i]  <= nv6_reg[i];
            end
        end
    end

    assign out_valid = v_reg[7];
    assign new_pos   = pos7_reg;
    assign new_vel   = nv7_reg;

endmodule

// ===== sv/boris_particle_push.sv =====
// Throughput: one item per cycle through the seven-stage pipeline unless
// out_stall or a configuration write stalls the input. A configuration write
// stalls the input from the write cycle until the coefficient unit is idle,
// while the serial dividers rebuild the scale vector. Reset zeroes the
// config and coefficient registers and empties the pipeline; no pass runs.
// ----------------------------------------------------------------------------
// Boris particle pusher
// Advances one particle per item by one Boris step in uniform fields.
// ----------------------------------------------------------------------------
module boris_particle_push
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  word_t            cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  word_t            pos_x,
    input  word_t            pos_y,
    input  word_t            pos_z,
    input  word_t            vel_x,
    input  word_t            vel_y,
    input  word_t            vel_z,
    output logic             out_valid,
    input  logic             out_stall,
    output word_t            new_pos_x,
    output word_t            new_pos_y,
    output word_t            new_pos_z,
    output word_t            new_vel_x,
    output word_t            new_vel_y,
    output word_t            new_vel_z
);

    coef_t coef;
    logic  busy;
    logic  ready;
    logic  acc;
    vec3_t pos;
    vec3_t vel;
    vec3_t np;
    vec3_t nv;

    bpp_coef #(
        .FRAC_BITS(FRAC_BITS)
    ) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (busy)
    );

    assign pos[0]   = pos_x;
    assign pos[1]   = pos_y;
    assign pos[2]   = pos_z;
    assign vel[0]   = vel_x;
    assign vel[1]   = vel_y;
    assign vel[2]   = vel_z;
    assign in_stall = !ready || busy || cfg_we;
    assign acc      = in_valid && !in_stall;

    bpp_pipe #(
        .FRAC_BITS(FRAC_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (acc),
        .in_ready  (ready),
        .pos       (pos),
        .vel       (vel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_pos   (np),
        .new_vel   (nv)
    );

    assign new_pos_x = np[0];
    assign new_pos_y = np[1];
    assign new_pos_z = np[2];
    assign new_vel_x = nv[0];
    assign new_vel_y = nv[1];
    assign new_vel_z = nv[2];

endmodule

// ===== sv/bpp_check.sv =====
// ----------------------------------------------------------------------------
// Boris pusher port checker
// Watches the top-level ports for handshake and configuration behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpp_check (
    input logic clk,
    input logic rst_n,
    input logic cfg_we,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_SAME(a_cfg_blocks, clk, rst_n, cfg_we, in_stall)
    `ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_we, in_stall)

endmodule

bind boris_particle_push bpp_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
